[rtl/dsp_pkg.sv]
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types and constants of the debounced speed panel.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int SPEED_BITS = 13;
  localparam int BUTTONS = 4;

  localparam int DEBOUNCE_BITS = 16;
  localparam int STEP_BITS = 8;
  localparam int LIMIT_BITS = 12;

  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = DEBOUNCE_BITS'(50);
  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(10);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(800);
  localparam logic signed [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(200);

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_STEP     = 2'd1,
    REG_LIMIT    = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_UNSET = 2'd0,
    MODE_STAR  = 2'd1,
    MODE_MOON  = 2'd2
  } mode_t;

  // button order within a vector
  localparam int BTN_REVERSE = 0;
  localparam int BTN_ENABLE  = 1;
  localparam int BTN_SLOWER  = 2;
  localparam int BTN_FASTER  = 3;

  typedef struct packed {
    logic reverse_level;
    logic enable_level;
    logic slower_level;
    logic faster_level;
    logic switch_level;
  } request_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] motor_speed;
    logic                         motor_on;
    logic [1:0]                   tracking_mode;
    logic                         slot_saved;
    logic                         mode_loaded;
  } result_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic               switch_settled;
    logic               switch_level;
    logic [BUTTONS-1:0] press;
  } event_t;

endpackage

[rtl/dsp_front.sv]
// ----------------------------------------------------------------------------
// dsp_front
// Debounces the button and switch levels of each tick and classifies the
// tick into press edges and a settled switch level.
// ----------------------------------------------------------------------------
module dsp_front
  import dsp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  request_t                 req,
  input  logic [DEBOUNCE_BITS-1:0] debounce_ticks,
  output event_t                   evt
);

  localparam int LINES = BUTTONS + 1;
  localparam int CMP_W = (COUNT_BITS > DEBOUNCE_BITS) ? COUNT_BITS : DEBOUNCE_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [LINES-1:0]      last_raw;
  logic [COUNT_BITS-1:0] count [LINES];
  logic [BUTTONS-1:0]    stable;

  logic [LINES-1:0]      level;
  logic [LINES-1:0]      settled;
  logic [COUNT_BITS-1:0] count_next [LINES];
  logic [BUTTONS-1:0]    stable_next;

  assign level = {req.switch_level, req.faster_level, req.slower_level,
                  req.enable_level, req.reverse_level};

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      if (level[i] != last_raw[i]) begin
        count_next[i] = '0;
      end else if (count[i] != COUNT_MAX) begin
        count_next[i] = count[i] + 1'b1;
      end else begin
        count_next[i] = count[i];
      end
      settled[i] = CMP_W'(count_next[i]) > CMP_W'(debounce_ticks);
    end
    for (int i = 0; i < BUTTONS; i++) begin
      stable_next[i] = stable[i];
      evt.press[i] = 1'b0;
      if (settled[i] && level[i] != stable[i]) begin
        stable_next[i] = level[i];
        evt.press[i] = !level[i];
      end
    end
    evt.switch_settled = settled[BUTTONS];
    evt.switch_level = level[BUTTONS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= '1;
      stable <= '0;
      for (int i = 0; i < LINES; i++) begin
        count[i] <= '0;
      end
    end else if (accept) begin
      last_raw <= level;
      stable <= stable_next;
      for (int i = 0; i < LINES; i++) begin
        count[i] <= count_next[i];
      end
    end
  end

endmodule

[rtl/dsp_queue.sv]
// ----------------------------------------------------------------------------
// dsp_queue
// Two-entry queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
module dsp_queue
  import dsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t push_data,
  input  logic   pop,
  output event_t pop_data,
  output logic   full,
  output logic   empty
);

  event_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/dsp_back.sv]
// ----------------------------------------------------------------------------
// dsp_back
// Applies classified ticks to mode, speed, slots and enable, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module dsp_back
  import dsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  evt_valid,
  input  event_t                evt,
  output logic                  evt_pop,
  input  logic [STEP_BITS-1:0]  speed_step,
  input  logic [LIMIT_BITS-1:0] speed_limit,
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res_data
);

  localparam int W = SPEED_BITS + 2;

  mode_t                        mode;
  logic signed [SPEED_BITS-1:0] speed;
  logic signed [SPEED_BITS-1:0] slots [2];
  logic                         enabled;

  mode_t                        mode_next;
  logic                         loaded;
  logic                         saved;
  logic                         slot_idx;
  logic signed [W-1:0]          s0;
  logic signed [W-1:0]          s1;
  logic signed [W-1:0]          s2;
  logic signed [W-1:0]          s3;
  logic signed [W-1:0]          v2;
  logic signed [W-1:0]          v3;
  logic signed [W-1:0]          step_w;
  logic signed [W-1:0]          lim_w;
  logic signed [SPEED_BITS-1:0] speed_next;
  logic                         enabled_next;

  assign evt_pop = evt_valid && (!res_valid || res_ready);
  assign step_w = W'(speed_step);
  assign lim_w = W'(speed_limit);

  always_comb begin
    mode_next = mode;
    loaded = 1'b0;
    if (evt.switch_settled) begin
      if (evt.switch_level && mode != MODE_MOON) begin
        mode_next = MODE_MOON;
        loaded = 1'b1;
      end else if (!evt.switch_level && mode != MODE_STAR) begin
        mode_next = MODE_STAR;
        loaded = 1'b1;
      end
    end
    slot_idx = mode_next == MODE_MOON;
    s0 = loaded ? W'(slots[slot_idx]) : W'(speed);
    s1 = evt.press[BTN_REVERSE] ? -s0 : s0;

    // slower: toward zero
    if (s1 >= 0) begin
      v2 = s1 - step_w;
      s2 = (v2 < 0) ? '0 : v2;
    end else begin
      v2 = s1 + step_w;
      s2 = (v2 > 0) ? '0 : v2;
    end
    if (!evt.press[BTN_SLOWER]) begin
      s2 = s1;
    end

    // faster: away from zero, limited
    if (s2 >= 0) begin
      v3 = s2 + step_w;
      s3 = (v3 > lim_w) ? lim_w : v3;
    end else begin
      v3 = s2 - step_w;
      s3 = (v3 < -lim_w) ? -lim_w : v3;
    end
    if (!evt.press[BTN_FASTER]) begin
      s3 = s2;
    end

    speed_next = s3[SPEED_BITS-1:0];
    saved = evt.press[BTN_REVERSE] || evt.press[BTN_SLOWER] || evt.press[BTN_FASTER];
    enabled_next = enabled ^ evt.press[BTN_ENABLE];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_UNSET;
      speed <= SPEED_RESET;
      slots[0] <= SPEED_RESET;
      slots[1] <= SPEED_RESET;
      enabled <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (evt_pop) begin
        mode <= mode_next;
        speed <= speed_next;
        enabled <= enabled_next;
        if (saved) begin
          slots[slot_idx] <= speed_next;
        end
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_pop) begin
      res_data.motor_speed <= speed_next;
      res_data.motor_on <= enabled_next;
      res_data.tracking_mode <= mode_next;
      res_data.slot_saved <= saved;
      res_data.mode_loaded <= loaded;
    end
  end

endmodule

[rtl/debounced_speed_panel.sv]
// ----------------------------------------------------------------------------
// debounced_speed_panel
// Button and mode switch panel of a tracking motor drive: debounces the
// raw levels and keeps speed, direction, enable and per-mode speed slots.
//
// One request is one millisecond tick with the raw levels of the reverse,
// enable, slower and faster buttons (low when pressed) and the mode switch.
// Every request gives exactly one result: signed speed, motor enable,
// tracking mode and flags for a slot write and a mode load.
// Requests are taken with valid/ready on req_*, results leave on res_*.
// A request is registered in the queue and its result in the output register,
// and one request per cycle is sustained while the receiver takes results;
// the debounce front and the speed back are parted by a two-entry queue and
// the result sits in an output register. When the receiver stalls, the
// output register holds, the queue fills and req_ready drops once both
// entries are taken. Reset clears the queue, sets the registers to debounce
// 50, step 10 and limit 800, the speed and both slots to 200, mode unset and
// motor off. The user must write the registers over the APB port only while
// no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module debounced_speed_panel
  import dsp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  request_t             req_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output result_t              res_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  logic [DEBOUNCE_BITS-1:0] debounce_ticks;
  logic [STEP_BITS-1:0]     speed_step;
  logic [LIMIT_BITS-1:0]    speed_limit;

  logic       reg_write;
  logic [1:0] reg_sel;

  logic   accept;
  event_t front_evt;
  event_t queue_evt;
  logic   queue_full;
  logic   queue_empty;
  logic   evt_pop;

  assign pready = 1'b1;
  assign reg_sel = paddr[3:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      speed_step <= STEP_RESET;
      speed_limit <= LIMIT_RESET;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_DEBOUNCE: debounce_ticks <= pwdata[DEBOUNCE_BITS-1:0];
        REG_STEP:     speed_step <= pwdata[STEP_BITS-1:0];
        REG_LIMIT:    speed_limit <= pwdata[LIMIT_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEBOUNCE: prdata = DATA_BITS'(debounce_ticks);
      REG_STEP:     prdata = DATA_BITS'(speed_step);
      REG_LIMIT:    prdata = DATA_BITS'(speed_limit);
      default:      prdata = '0;
    endcase
  end

  assign req_ready = !queue_full;
  assign accept = req_valid && req_ready;

  dsp_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .req           (req_data),
    .debounce_ticks(debounce_ticks),
    .evt           (front_evt)
  );

  dsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(front_evt),
    .pop      (evt_pop),
    .pop_data (queue_evt),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  dsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .evt_valid  (!queue_empty),
    .evt        (queue_evt),
    .evt_pop    (evt_pop),
    .speed_step (speed_step),
    .speed_limit(speed_limit),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

endmodule

[test/tb_debounced_speed_panel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_speed_panel
// Self-checking bench for the debounced speed panel. A shadow copy of the
// panel (debounce counters, mode, speed, slots, enable) predicts the result
// of every accepted tick request; results are compared field by field in
// order. Register settings are changed over APB between phases, covering
// zero and saturating debounce, zero and full step, zero and full limit.
// Tick streams are mostly clean presses with random timing plus bounces,
// with random gaps and stalls on both handshakes.
// ----------------------------------------------------------------------------
import dsp_pkg::*;

class panel_mirror;
  int unsigned debounce_ticks;
  int unsigned step_size;
  int unsigned speed_cap;
  bit          line_stable[BUTTONS];
  bit          line_last[BUTTONS+1];
  int unsigned line_quiet[BUTTONS+1];
  mode_t       mode;
  int          speed;
  int          slots[2];
  bit          enabled;
  result_t     results_due[$];
  int unsigned mismatches;
  int unsigned results_seen;

  function new();
    debounce_ticks = DEBOUNCE_RESET;
    step_size = STEP_RESET;
    speed_cap = LIMIT_RESET;
    for (int i = 0; i < BUTTONS; i++) begin
      line_stable[i] = 1'b0;
    end
    for (int i = 0; i <= BUTTONS; i++) begin
      line_last[i] = 1'b1;
      line_quiet[i] = 0;
    end
    mode = MODE_UNSET;
    speed = int'(SPEED_RESET);
    slots[0] = int'(SPEED_RESET);
    slots[1] = int'(SPEED_RESET);
    enabled = 1'b0;
    mismatches = 0;
    results_seen = 0;
  endfunction

  function bit holds_register(logic [ADDR_BITS-1:0] addr);
    return addr[1:0] == 2'b00 && addr[ADDR_BITS-1:2] <= REG_LIMIT;
  endfunction

  function void set_register(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] value);
    if (addr[1:0] == 2'b00) begin
      case (addr[ADDR_BITS-1:2])
        REG_DEBOUNCE: debounce_ticks = value[DEBOUNCE_BITS-1:0];
        REG_STEP:     step_size = value[STEP_BITS-1:0];
        REG_LIMIT:    speed_cap = value[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  endfunction

  function logic [DATA_BITS-1:0] register_value(logic [ADDR_BITS-1:0] addr);
    case (addr[ADDR_BITS-1:2])
      REG_DEBOUNCE: return DATA_BITS'(debounce_ticks);
      REG_STEP:     return DATA_BITS'(step_size);
      REG_LIMIT:    return DATA_BITS'(speed_cap);
      default:      return '0;
    endcase
  endfunction

  // saturating quiet counter, cleared on a level change
  function bit settle(int idx, bit level);
    if (level != line_last[idx]) begin
      line_quiet[idx] = 0;
    end else if (line_quiet[idx] < (32'd1 << COUNT_BITS_DEFAULT) - 1) begin
      line_quiet[idx]++;
    end
    line_last[idx] = level;
    return line_quiet[idx] > debounce_ticks;
  endfunction

  function bit pressed(int btn, bit level);
    if (settle(btn, level) && level != line_stable[btn]) begin
      line_stable[btn] = level;
      return level == 1'b0;
    end
    return 1'b0;
  endfunction

  function int slot_of();
    return (mode == MODE_MOON) ? 1 : 0;
  endfunction

  function void take_tick(request_t r);
    result_t want;
    bit      saved;
    bit      loaded;
    int      stp;
    int      cap;
    saved = 1'b0;
    loaded = 1'b0;
    stp = int'(step_size);
    cap = int'(speed_cap);
    if (settle(BUTTONS, r.switch_level)) begin
      if (r.switch_level && mode != MODE_MOON) begin
        mode = MODE_MOON;
        loaded = 1'b1;
      end else if (!r.switch_level && mode != MODE_STAR) begin
        mode = MODE_STAR;
        loaded = 1'b1;
      end
      if (loaded) speed = slots[slot_of()];
    end
    if (pressed(BTN_REVERSE, r.reverse_level)) begin
      speed = -speed;
      slots[slot_of()] = speed;
      saved = 1'b1;
    end
    if (pressed(BTN_ENABLE, r.enable_level)) enabled = ~enabled;
    if (pressed(BTN_SLOWER, r.slower_level)) begin
      if (speed >= 0) speed = (speed - stp < 0) ? 0 : speed - stp;
      else speed = (speed + stp > 0) ? 0 : speed + stp;
      slots[slot_of()] = speed;
      saved = 1'b1;
    end
    if (pressed(BTN_FASTER, r.faster_level)) begin
      if (speed >= 0) speed = (speed + stp > cap) ? cap : speed + stp;
      else speed = (speed - stp < -cap) ? -cap : speed - stp;
      slots[slot_of()] = speed;
      saved = 1'b1;
    end
    want.motor_speed = speed[SPEED_BITS-1:0];
    want.motor_on = enabled;
    want.tracking_mode = mode;
    want.slot_saved = saved;
    want.mode_loaded = loaded;
    results_due.push_back(want);
  endfunction

  task report(string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", what);
  endtask

  task check_result(result_t got);
    result_t want;
    results_seen++;
    if (results_due.size() == 0) begin
      report($sformatf("result %0d arrived with no request pending", results_seen));
      return;
    end
    want = results_due.pop_front();
    if (got.motor_speed !== want.motor_speed)
      report($sformatf("result %0d motor_speed %0d, want %0d", results_seen,
                       got.motor_speed, want.motor_speed));
    if (got.motor_on !== want.motor_on)
      report($sformatf("result %0d motor_on %b, want %b", results_seen,
                       got.motor_on, want.motor_on));
    if (got.tracking_mode !== want.tracking_mode)
      report($sformatf("result %0d tracking_mode %0d, want %0d", results_seen,
                       got.tracking_mode, want.tracking_mode));
    if (got.slot_saved !== want.slot_saved)
      report($sformatf("result %0d slot_saved %b, want %b", results_seen,
                       got.slot_saved, want.slot_saved));
    if (got.mode_loaded !== want.mode_loaded)
      report($sformatf("result %0d mode_loaded %b, want %b", results_seen,
                       got.mode_loaded, want.mode_loaded));
  endtask
endclass

module tb_debounced_speed_panel;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD = 64;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int SWITCH_BIT = 0;
  localparam logic [ADDR_BITS-1:0] SPARE_ADDR = ADDR_BITS'(12);
  localparam request_t NO_QUIET = '0;
  // reverse, slower and moon position linger so faster presses dominate
  localparam request_t FAST_RUN = '{reverse_level: 1'b1, enable_level: 1'b0,
                                    slower_level: 1'b1, faster_level: 1'b0,
                                    switch_level: 1'b1};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  request_t             req_data = '1;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  result_t              res_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  panel_mirror mirror;
  request_t    line_levels = '1;
  int unsigned line_hold[BUTTONS+1];
  bit          calm = 1'b0;
  bit          hold_results = 1'b0;
  int unsigned stalled_cycles = 0;

  debounced_speed_panel DUT (
    .clk, .rst, .req_valid, .req_ready, .req_data, .res_valid, .res_ready, .res_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic request_t levels(bit rev, bit en, bit slo, bit fas, bit sw);
    request_t r;
    r.reverse_level = rev;
    r.enable_level = en;
    r.slower_level = slo;
    r.faster_level = fas;
    r.switch_level = sw;
    return r;
  endfunction

  // ticks a line keeps its level after a change; short ones are bounces
  function automatic int unsigned pick_hold(int idx, int unsigned base, request_t quiet);
    int unsigned h;
    if ($urandom_range(0, 9) < 2) h = $urandom_range(0, base);
    else h = base + $urandom_range(1, 4);
    if (quiet[idx] && line_levels[idx]) h = h * 6 + 6;
    if (idx == SWITCH_BIT) h = h + $urandom_range(0, 12);
    return h;
  endfunction

  // all driving tasks start and end at a falling edge
  task automatic send_tick(input request_t r);
    int unsigned gap;
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    mirror.take_tick(r);
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic hold_request(input request_t r, input int n);
    repeat (n) send_tick(r);
  endtask

  task automatic run_ticks(input int count, input int unsigned base, input request_t quiet);
    for (int i = 0; i <= BUTTONS; i++) begin
      line_hold[i] = pick_hold(i, base, quiet);
    end
    repeat (count) begin
      for (int i = 0; i <= BUTTONS; i++) begin
        if (line_hold[i] == 0) begin
          line_levels[i] = ~line_levels[i];
          line_hold[i] = pick_hold(i, base, quiet);
        end else begin
          line_hold[i]--;
        end
      end
      send_tick(line_levels);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (mirror.results_due.size() != 0) @(negedge clk);
  endtask

  task automatic apb_transfer(input bit wr, input logic [ADDR_BITS-1:0] addr,
                              input logic [DATA_BITS-1:0] value,
                              output logic [DATA_BITS-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [ADDR_BITS-1:0] addr,
                                input logic [DATA_BITS-1:0] value);
    logic [DATA_BITS-1:0] readback;
    apb_transfer(1'b1, addr, value, readback);
    mirror.set_register(addr, value);
    if (mirror.holds_register(addr)) begin
      apb_transfer(1'b0, addr, '0, readback);
      if (readback !== mirror.register_value(addr))
        mirror.report($sformatf("register at %0d reads %0h, want %0h", addr, readback,
                                mirror.register_value(addr)));
    end
  endtask

  task automatic set_panel(input logic [DATA_BITS-1:0] deb, input logic [DATA_BITS-1:0] stp,
                           input logic [DATA_BITS-1:0] cap);
    write_register({REG_DEBOUNCE, 2'b00}, deb);
    write_register({REG_STEP, 2'b00}, stp);
    write_register({REG_LIMIT, 2'b00}, cap);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) mirror.check_result(res_data);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side: random stalls, plus a long hold on request
  initial begin
    int unsigned stall;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        res_ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          res_ready <= 1'b1;
        end else begin
          res_ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    mirror = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unmapped register write must change nothing
    write_register(SPARE_ADDR, 32'h0000_00FF);
    set_panel(0, 255, 4095);

    // directed presses with immediate debounce
    hold_request(levels(1, 1, 1, 1, 1), 2);
    hold_request(levels(0, 0, 0, 0, 0), 2);
    hold_request(levels(1, 1, 1, 1, 1), 2);
    hold_request(levels(1, 1, 1, 0, 1), 2);
    hold_request(levels(1, 1, 1, 1, 1), 2);
    hold_request(levels(0, 1, 1, 1, 1), 2);
    hold_request(levels(1, 1, 1, 1, 1), 2);
    hold_request(levels(1, 1, 1, 0, 1), 2);
    hold_request(levels(1, 1, 1, 1, 1), 1);
    hold_request(levels(1, 1, 0, 1, 1), 1);
    hold_request(levels(1, 1, 1, 1, 1), 1);
    hold_request(levels(1, 0, 1, 1, 1), 2);
    hold_request(levels(1, 1, 1, 1, 1), 2);
    line_levels = levels(1, 1, 1, 1, 1);
    drain();

    // speed above a tiny limit gets clamped
    set_panel(0, 1, 1);
    calm = 1'b1;
    run_ticks(150, 0, NO_QUIET);
    drain();

    // zero step and zero limit
    set_panel(1, 0, 0);
    calm = 1'b0;
    run_ticks(100, 1, NO_QUIET);
    drain();

    // run the speed up to full scale while results back up
    set_panel(3, 255, 4095);
    hold_results = 1'b1;
    run_ticks(250, 3, FAST_RUN);
    drain();

    set_panel(2, 37, 100);
    run_ticks(150, 2, NO_QUIET);
    drain();

    // saturated debounce: no level ever settles
    set_panel(32'hFFFF_FFFF, 128, 2048);
    calm = 1'b1;
    run_ticks(80, 6, NO_QUIET);
    drain();

    set_panel(0, 128, 2048);
    calm = 1'b0;
    run_ticks(120, 0, NO_QUIET);
    drain();

    set_panel(DEBOUNCE_RESET, STEP_RESET, LIMIT_RESET);
    hold_results = 1'b1;
    run_ticks(300, DEBOUNCE_RESET, NO_QUIET);
    drain();

    set_panel(5, 200, 3000);
    run_ticks(180, 5, NO_QUIET);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.results_due.size() != 0)
      mirror.report($sformatf("%0d results never arrived", mirror.results_due.size()));
    if (mirror.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
